>>> rtl/qpse_pkg.sv
// ----------------------------------------------------------------------------
// qpse_pkg
// Shared types, codes and defaults of the qutrit pulse state evolver.
// ----------------------------------------------------------------------------
`default_nettype none

package qpse_pkg;

	localparam int DIM_DEF   = 3;
	localparam int FRAC_DEF  = 30;
	localparam int LEVELS    = 3;
	localparam int NUM_MATS  = 3;

	// func codes
	localparam logic [2:0] FN_LOAD_MAT  = 3'd0;
	localparam logic [2:0] FN_LOAD_BAS  = 3'd1;
	localparam logic [2:0] FN_LOAD_ST   = 3'd2;
	localparam logic [2:0] FN_APPLY     = 3'd3;
	localparam logic [2:0] FN_MEASURE   = 3'd4;

	// table_sel code that selects no table
	localparam logic [1:0] SEL_NONE     = 2'd3;

	// pulse symbol codes (two's complement)
	localparam logic [1:0] SYM_NEG      = 2'b11;
	localparam logic [1:0] SYM_POS      = 2'b01;

	// matrix numbers
	localparam logic [1:0] MAT_NONE     = 2'd0;
	localparam logic [1:0] MAT_NEG      = 2'd1;
	localparam logic [1:0] MAT_POS      = 2'd2;

	// tag that travels with each product through the pipeline
	typedef struct packed {
		logic       vld;
		logic       first;  // first term of a sum
		logic       last;   // last term of a sum
		logic       meas;   // projection (conjugated coefficient)
		logic [2:0] row;    // output row, or basis level
		logic [2:0] col;    // state component read
	} tag_t;

	function automatic logic [1:0] sym_to_mat(input logic [1:0] sym);
		logic [1:0] m;
		m = MAT_NONE;
		if (sym == SYM_NEG)
			m = MAT_NEG;
		else if (sym == SYM_POS)
			m = MAT_POS;
		return m;
	endfunction

endpackage

`default_nettype wire

>>> rtl/qpse_ram.sv
// ----------------------------------------------------------------------------
// qpse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qpse_ram #(
	parameter int W = 64,
	parameter int D = 36
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/qpse_datapath.sv
// ----------------------------------------------------------------------------
// qpse_datapath
// Shared complex multiply-accumulate, rounding, and projection probability.
// ----------------------------------------------------------------------------
`default_nettype none

module qpse_datapath #(
	parameter int DIM       = qpse_pkg::DIM_DEF,
	parameter int FRAC_BITS = qpse_pkg::FRAC_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire qpse_pkg::tag_t tag_s1,
	input  wire logic [63:0]    coef_s1,
	input  wire logic [63:0]    state_s1,
	output logic                busy,
	output logic                st_we,
	output logic [2:0]          st_wrow,
	output logic [63:0]         st_wdata,
	output logic                prob_we,
	output logic [1:0]          prob_k,
	output logic [30:0]         prob_val
);

	localparam int AW = 64 + $clog2(2 * DIM) + 1;
	localparam logic signed [AW-1:0] SMAX = AW'(64'sh7FFF_FFFF);
	localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
	localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

	qpse_pkg::tag_t tag_s2, tag_s3, tag_s4, tag_s5;

	logic signed [63:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	logic signed [31:0] pr_s4, pi_s4;
	logic [63:0] sqr_s5, sqi_s5;

	logic signed [31:0] ar, ai, xr, xi;
	logic signed [AW-1:0] t_re, t_im, e1, e2, e3, e4;
	logic signed [31:0] r_re, r_im;
	logic [63:0] sq_sum, sq_rnd;

	// round to nearest (ties up), then saturate to 32 bits
	function automatic logic signed [31:0] rsat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] t;
		t = (v + HALF) >>> FRAC_BITS;
		if (t > SMAX)
			t = SMAX;
		else if (t < SMIN)
			t = SMIN;
		return t[31:0];
	endfunction

	assign ar = coef_s1[63:32];
	assign ai = coef_s1[31:0];
	assign xr = state_s1[63:32];
	assign xi = state_s1[31:0];

	// stage 2: four partial products
	always_ff @(posedge clk) begin
		p1_s2 <= ar * xr;
		p2_s2 <= ai * xi;
		p3_s2 <= ar * xi;
		p4_s2 <= ai * xr;
	end

	// stage 3: accumulate; projection uses the conjugate coefficient
	assign e1 = AW'(p1_s2);
	assign e2 = AW'(p2_s2);
	assign e3 = AW'(p3_s2);
	assign e4 = AW'(p4_s2);
	assign t_re = tag_s2.meas ? (e1 + e2) : (e1 - e2);
	assign t_im = tag_s2.meas ? (e3 - e4) : (e3 + e4);

	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			acc_re_q <= (tag_s2.first ? '0 : acc_re_q) + t_re;
			acc_im_q <= (tag_s2.first ? '0 : acc_im_q) + t_im;
		end
	end

	// round the finished sums
	assign r_re = rsat(acc_re_q);
	assign r_im = rsat(acc_im_q);

	assign st_we    = tag_s3.vld && !tag_s3.meas;
	assign st_wrow  = tag_s3.row;
	assign st_wdata = {r_re, r_im};

	// stage 4/5: squared magnitude of the projection
	always_ff @(posedge clk) begin
		pr_s4  <= r_re;
		pi_s4  <= r_im;
		sqr_s5 <= 64'(pr_s4 * pr_s4);
		sqi_s5 <= 64'(pi_s4 * pi_s4);
	end

	assign sq_sum = sqr_s5 + sqi_s5;
	assign sq_rnd = (sq_sum >> FRAC_BITS) + 64'(sq_sum[FRAC_BITS-1]);

	assign prob_we  = tag_s5.vld;
	assign prob_k   = tag_s5.row[1:0];
	assign prob_val = (sq_rnd > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sq_rnd[30:0];

	// tag pipeline; s3 keeps only finished sums, s4 only projections
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= {tag_s2.vld && tag_s2.last, tag_s2.first, tag_s2.last,
				tag_s2.meas, tag_s2.row, tag_s2.col};
			tag_s4 <= {tag_s3.vld && tag_s3.meas, tag_s3.first, tag_s3.last,
				tag_s3.meas, tag_s3.row, tag_s3.col};
			tag_s5 <= tag_s4;
		end
	end

	assign busy = tag_s2.vld || tag_s3.vld || tag_s4.vld || tag_s5.vld;

endmodule

`default_nettype wire

>>> rtl/qutrit_pulse_state_evolver_core.sv
// ----------------------------------------------------------------------------
// qutrit_pulse_state_evolver_core
// Complex state vector evolution by pulse step matrices, with projection.
// ----------------------------------------------------------------------------
// Loads are written as they are accepted. An apply issues DIM*DIM MACs, one per
// cycle, then drains; the next item is accepted once the bank has swapped.
// A measure issues 3*DIM MACs, drains and loads the output register; the next
// item is accepted after that load, later while a result beat is held.
// One item is in work at a time.
// Reset zeroes the state vector (valid bits); matrix and basis RAMs are not.
`default_nettype none

module qutrit_pulse_state_evolver_core #(
	parameter int DIM       = qpse_pkg::DIM_DEF,
	parameter int FRAC_BITS = qpse_pkg::FRAC_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic [1:0]         table_sel,
	input  wire logic [1:0]         row,
	input  wire logic [1:0]         col,
	input  wire logic signed [31:0] value_re,
	input  wire logic signed [31:0] value_im,
	input  wire logic signed [1:0]  pulse_symbol,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [30:0]             prob_level0,
	output logic [30:0]             prob_level1,
	output logic [30:0]             prob_level2,
	output logic signed [31:0]      state_re0,
	output logic signed [31:0]      state_im0,
	output logic signed [31:0]      state_re1,
	output logic signed [31:0]      state_im1,
	output logic signed [31:0]      state_re2,
	output logic signed [31:0]      state_im2
);

	localparam int IW     = $clog2(DIM);
	localparam int CW     = (IW > 2) ? IW : 2;
	localparam int CDEPTH = qpse_pkg::NUM_MATS * DIM * DIM + qpse_pkg::LEVELS * DIM;
	localparam int CAW    = $clog2(CDEPTH);
	localparam int SDEPTH = 2 * DIM;
	localparam int SAW    = $clog2(SDEPTH);
	localparam int BBASE  = qpse_pkg::NUM_MATS * DIM * DIM;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} fsm_t;

	fsm_t           state_q;
	logic           bank_q;
	logic [DIM-1:0] valid_q;
	logic           meas_q;
	logic [1:0]     msel_q;
	logic [IW-1:0]  inner_q;
	logic [CW-1:0]  outer_q;
	qpse_pkg::tag_t tag_s1;

	logic        acc_in, busy;
	logic        row_ok, col_ok;
	logic        c_we, s_we;
	logic [CAW-1:0] c_waddr, c_raddr;
	logic [SAW-1:0] s_waddr, s_raddr;
	logic [63:0] s_wdata, c_rd, s_rd, s_x;
	logic        inner_last, outer_last;

	logic        dp_st_we, dp_prob_we;
	logic [2:0]  dp_st_wrow;
	logic [63:0] dp_st_wdata;
	logic [1:0]  dp_prob_k;
	logic [30:0] dp_prob_val;

	logic [30:0] prob_q [qpse_pkg::LEVELS];
	logic [63:0] stc_q  [DIM];
	logic [63:0] comp   [3];

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;
	assign row_ok   = (int'(row) < DIM);
	assign col_ok   = (int'(col) < DIM);

	// coefficient memory write: matrix and basis loads
	always_comb begin
		c_we    = 1'b0;
		c_waddr = CAW'(int'(table_sel) * DIM * DIM + int'(row) * DIM + int'(col));
		if (acc_in && table_sel != qpse_pkg::SEL_NONE && row_ok) begin
			if (func == qpse_pkg::FN_LOAD_MAT && col_ok)
				c_we = 1'b1;
			if (func == qpse_pkg::FN_LOAD_BAS) begin
				c_we    = 1'b1;
				c_waddr = CAW'(BBASE + int'(table_sel) * DIM + int'(row));
			end
		end
	end

	// state memory write: direct load into the live bank, MAC results into the other
	always_comb begin
		if (dp_st_we) begin
			s_we    = 1'b1;
			s_waddr = SAW'(int'(!bank_q) * DIM + int'(dp_st_wrow));
			s_wdata = dp_st_wdata;
		end else begin
			s_we    = acc_in && func == qpse_pkg::FN_LOAD_ST && row_ok;
			s_waddr = SAW'(int'(bank_q) * DIM + int'(row));
			s_wdata = {value_re, value_im};
		end
	end

	// read addresses for the current MAC issue
	assign c_raddr = meas_q
		? CAW'(BBASE + int'(outer_q) * DIM + int'(inner_q))
		: CAW'(int'(msel_q) * DIM * DIM + int'(outer_q) * DIM + int'(inner_q));
	assign s_raddr = SAW'(int'(bank_q) * DIM + int'(inner_q));

	qpse_ram #(.W(64), .D(CDEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata ({value_re, value_im}),
		.raddr (c_raddr),
		.rdata (c_rd)
	);

	qpse_ram #(.W(64), .D(SDEPTH)) u_state_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rd)
	);

	// never-written state components read as zero
	assign s_x = valid_q[tag_s1.col[IW-1:0]] ? s_rd : 64'd0;

	qpse_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.coef_s1  (c_rd),
		.state_s1 (s_x),
		.busy     (busy),
		.st_we    (dp_st_we),
		.st_wrow  (dp_st_wrow),
		.st_wdata (dp_st_wdata),
		.prob_we  (dp_prob_we),
		.prob_k   (dp_prob_k),
		.prob_val (dp_prob_val)
	);

	assign inner_last = (int'(inner_q) == DIM - 1);
	assign outer_last = meas_q ? (int'(outer_q) == qpse_pkg::LEVELS - 1)
	                           : (int'(outer_q) == DIM - 1);

	// issue tag, aligned with the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld   <= (state_q == ST_RUN);
			tag_s1.first <= (inner_q == '0);
			tag_s1.last  <= inner_last;
			tag_s1.meas  <= meas_q;
			tag_s1.row   <= 3'(outer_q);
			tag_s1.col   <= 3'(inner_q);
		end
	end

	// measure captures: state while projecting on basis 0, and probabilities
	always_ff @(posedge clk) begin
		if (tag_s1.vld && tag_s1.meas && tag_s1.row == 3'd0)
			stc_q[tag_s1.col[IW-1:0]] <= s_x;
		if (dp_prob_we)
			prob_q[dp_prob_k] <= dp_prob_val;
	end

	for (genvar k = 0; k < 3; k++) begin : g_comp
		if (k < DIM) begin : g_have
			assign comp[k] = stc_q[k];
		end else begin : g_zero
			assign comp[k] = 64'd0;
		end
	end

	// sequencer, bank and output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bank_q    <= 1'b0;
			valid_q   <= '0;
			meas_q    <= 1'b0;
			msel_q    <= qpse_pkg::MAT_NONE;
			inner_q   <= '0;
			outer_q   <= '0;
			out_valid <= 1'b0;
			prob_level0 <= '0;
			prob_level1 <= '0;
			prob_level2 <= '0;
			state_re0 <= '0;
			state_im0 <= '0;
			state_re1 <= '0;
			state_im1 <= '0;
			state_re2 <= '0;
			state_im2 <= '0;
		end else begin
			// ST_DONE refills the register itself
			if (out_valid && out_ready && state_q != ST_DONE)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					inner_q <= '0;
					outer_q <= '0;
					if (acc_in) begin
						if (func == qpse_pkg::FN_LOAD_ST && row_ok)
							valid_q[row[IW-1:0]] <= 1'b1;
						if (func == qpse_pkg::FN_APPLY) begin
							meas_q  <= 1'b0;
							msel_q  <= qpse_pkg::sym_to_mat(pulse_symbol);
							state_q <= ST_RUN;
						end
						if (func == qpse_pkg::FN_MEASURE) begin
							meas_q  <= 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (inner_last) begin
						inner_q <= '0;
						outer_q <= outer_q + CW'(1);
						if (outer_last)
							state_q <= ST_DRAIN;
					end else begin
						inner_q <= inner_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (!tag_s1.vld && !busy) begin
						if (meas_q) begin
							state_q <= ST_DONE;
						end else begin
							bank_q  <= !bank_q;
							valid_q <= '1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						prob_level0 <= prob_q[0];
						prob_level1 <= prob_q[1];
						prob_level2 <= prob_q[2];
						state_re0   <= comp[0][63:32];
						state_im0   <= comp[0][31:0];
						state_re1   <= comp[1][63:32];
						state_im1   <= comp[1][31:0];
						state_re2   <= comp[2][63:32];
						state_im2   <= comp[2][31:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
